// ===== hw/rtl/two_class_admission_wait_queue_macros.svh =====
// assertion macros for the two-class admission wait queue
// no dependencies; included by the checker module
`ifndef TWO_CLASS_ADMISSION_WAIT_QUEUE_MACROS_SVH
`define TWO_CLASS_ADMISSION_WAIT_QUEUE_MACROS_SVH

// same-cycle implication
`define AWQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/awq_pkg.sv =====
// shared types, constants and the wait-time function of the admission queue
// no dependencies
`timescale 1ns / 1ps
package awq_pkg;

    localparam int P_LIST_DEPTH = 64;
    localparam int ID_W         = 32;
    localparam int TIME_W       = 40;
    localparam int CAP_W        = 16;
    localparam int SLOT_W       = 8;

    // list / cell operations
    typedef logic [2:0] t_lop;
    localparam t_lop L_HOLD   = 3'd0;
    localparam t_lop L_MARK   = 3'd1;
    localparam t_lop L_SORT   = 3'd2;
    localparam t_lop L_COMMIT = 3'd3;
    localparam t_lop L_REMOVE = 3'd4;
    localparam t_lop L_SET_DL = 3'd5;
    localparam t_lop L_APPEND = 3'd6;

    typedef struct packed {
        t_lop op;
        logic phase;
    } t_list_ctl;

    typedef struct packed {
        logic live;
        logic hit;
    } t_scan;

    // (tier(slot) + 15) * 1000
    function automatic logic [17:0] wait_ms(input logic [15:0] slot);
        logic [7:0] tier;
        begin
            if (slot < 16'd5) begin
                tier = 8'd5;
            end else if (slot < 16'd10) begin
                tier = 8'd10;
            end else if (slot < 16'd20) begin
                tier = 8'd20;
            end else if (slot < 16'd50) begin
                tier = 8'd60;
            end else begin
                tier = 8'd120;
            end
            return 18'((32'(tier) + 32'd15) * 32'd1000);
        end
    endfunction

endpackage

// ===== hw/rtl/two_class_admission_wait_queue.sv =====
// top level of the two-class admission wait queue: sequencer and two wait lists
// depends on awq_pkg and awq_list
//
// A request is taken when start is high and busy is low. An always-admit
// request answers on the next cycle with slot 0. Any other request runs a
// mark step that flags live entries and client hits in every cell of both
// lists, then odd-even neighbor swaps that pack survivors to the front while
// the scan bits walk out of the list head to give the new counts and the
// hit position, then commits counts, decides, computes the deadline and
// applies the write, removal or append. o_done is high for exactly one cycle
// with o_slot and o_queue_full; the receiver cannot hold it off, so sample
// it then. The user must write max_admitted through i_cfg_we / i_cfg_wdata
// only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module two_class_admission_wait_queue import awq_pkg::*; #(
    parameter int LIST_DEPTH = P_LIST_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ID_W-1:0]   i_client_id,
    input  logic              i_always_admit,
    input  logic              i_priority_class,
    input  logic [CAP_W-1:0]  i_admitted_now,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_queue_full
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = $clog2(2 * LIST_DEPTH + 2);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MARK   = 3'd1;
    localparam logic [2:0] S_SORT   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DLCALC = 3'd5;
    localparam logic [2:0] S_APPLY  = 3'd6;

    // decided action
    localparam logic [2:0] A_NONE  = 3'd0;
    localparam logic [2:0] A_REM_P = 3'd1;
    localparam logic [2:0] A_REM_N = 3'd2;
    localparam logic [2:0] A_REF_P = 3'd3;
    localparam logic [2:0] A_REF_N = 3'd4;
    localparam logic [2:0] A_APP_P = 3'd5;
    localparam logic [2:0] A_APP_N = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_step;
    logic [CAP_W-1:0]  r_max;
    logic [ID_W-1:0]   r_id;
    logic              r_prio;
    logic [CAP_W-1:0]  r_online;
    logic [TIME_W-1:0] r_now;
    logic [SW-1:0]     r_slot, n_slot;
    logic              r_full, n_full;
    logic [2:0]        r_act, n_act;
    logic [CW-1:0]     r_addr, n_addr;
    logic [TIME_W-1:0] r_dl;
    logic              r_done;
    logic [SLOT_W-1:0] r_oslot;
    logic              r_ofull;

    t_list_ctl     p_ctl, n_ctl;
    logic [CW-1:0] p_count, n_count, p_pos, n_pos;
    logic          p_found, n_found;

    logic [SW-1:0] s_p, s_n, s_ap, s_an;
    logic [TIME_W:0] dl_sum;

    // next-state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start && !i_always_admit) n_state = S_MARK;
            S_MARK:   n_state = S_SORT;
            S_SORT:   if (r_step == CW'(LIST_DEPTH - 1)) n_state = S_COMMIT;
            S_COMMIT: n_state = S_DECIDE;
            S_DECIDE: n_state = S_DLCALC;
            S_DLCALC: n_state = S_APPLY;
            S_APPLY:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // decision on committed counts and scan results
    always_comb begin
        s_p  = SW'(p_pos) + 1'b1;
        s_n  = SW'(p_count) + SW'(n_pos) + 1'b1;
        s_ap = SW'(p_count) + 1'b1;
        s_an = SW'(p_count) + SW'(n_count) + 1'b1;
        n_slot = '0;
        n_full = 1'b0;
        n_act  = A_NONE;
        n_addr = '0;
        if (r_max == '0 ||
            (p_count == '0 && n_count == '0 && r_online < r_max)) begin
            n_act = A_NONE;
        end else if (p_found) begin
            n_addr = p_pos;
            if (32'(r_online) + 32'(s_p) <= 32'(r_max)) begin
                n_act = A_REM_P;
            end else begin
                n_act  = A_REF_P;
                n_slot = s_p;
            end
        end else if (n_found) begin
            n_addr = n_pos;
            if (32'(r_online) + 32'(s_n) <= 32'(r_max)) begin
                n_act = A_REM_N;
            end else begin
                n_act  = A_REF_N;
                n_slot = s_n;
            end
        end else if (r_prio) begin
            n_slot = s_ap;
            n_addr = p_count;
            if (p_count == CW'(LIST_DEPTH)) n_full = 1'b1;
            else                             n_act  = A_APP_P;
        end else begin
            n_slot = s_an;
            n_addr = n_count;
            if (n_count == CW'(LIST_DEPTH)) n_full = 1'b1;
            else                             n_act  = A_APP_N;
        end
    end

    // saturating deadline
    assign dl_sum = {1'b0, r_now} + (TIME_W + 1)'(wait_ms(16'(r_slot)));

    // list control
    always_comb begin
        p_ctl.phase = r_step[0];
        n_ctl.phase = r_step[0];
        p_ctl.op    = L_HOLD;
        n_ctl.op    = L_HOLD;
        case (r_state)
            S_MARK: begin
                p_ctl.op = L_MARK;
                n_ctl.op = L_MARK;
            end
            S_SORT: begin
                p_ctl.op = L_SORT;
                n_ctl.op = L_SORT;
            end
            S_COMMIT: begin
                p_ctl.op = L_COMMIT;
                n_ctl.op = L_COMMIT;
            end
            S_APPLY: begin
                case (r_act)
                    A_REM_P: p_ctl.op = L_REMOVE;
                    A_REM_N: n_ctl.op = L_REMOVE;
                    A_REF_P: p_ctl.op = L_SET_DL;
                    A_REF_N: n_ctl.op = L_SET_DL;
                    A_APP_P: p_ctl.op = L_APPEND;
                    A_APP_N: n_ctl.op = L_APPEND;
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_max   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) r_max <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    // bypass answers on the next beat
                    if (start && i_always_admit) r_done <= 1'b1;
                end
                S_MARK: r_step <= '0;
                S_SORT: r_step <= r_step + 1'b1;
                S_APPLY: r_done <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_id     <= i_client_id;
                    r_prio   <= i_priority_class;
                    r_online <= i_admitted_now;
                    r_now    <= i_now_ms;
                    r_oslot  <= '0;
                    r_ofull  <= 1'b0;
                end
            end
            S_DECIDE: begin
                r_slot <= n_slot;
                r_full <= n_full;
                r_act  <= n_act;
                r_addr <= n_addr;
            end
            S_DLCALC: begin
                r_dl <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
            end
            S_APPLY: begin
                r_oslot <= SLOT_W'(r_slot);
                r_ofull <= r_full;
            end
            default: begin
            end
        endcase
    end

    awq_list #(.LIST_DEPTH(LIST_DEPTH), .CW(CW)) u_prio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (p_ctl),
        .i_addr  (r_addr),
        .i_id    (r_id),
        .i_now   (r_now),
        .i_dl    (r_dl),
        .o_count (p_count),
        .o_found (p_found),
        .o_pos   (p_pos)
    );

    awq_list #(.LIST_DEPTH(LIST_DEPTH), .CW(CW)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_ctl),
        .i_addr  (r_addr),
        .i_id    (r_id),
        .i_now   (r_now),
        .i_dl    (r_dl),
        .o_count (n_count),
        .o_found (n_found),
        .o_pos   (n_pos)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_slot       = r_oslot;
    assign o_queue_full = r_ofull;

endmodule

// ===== hw/rtl/awq_cell.sv =====
// one queue entry: id, deadline, live flag and scan bits
// depends on awq_pkg
`timescale 1ns / 1ps
module awq_cell import awq_pkg::*; #(
    parameter int CW   = 7,
    parameter int IDX  = 0,
    parameter bit LAST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_list_ctl         i_ctl,
    input  logic [CW-1:0]     i_addr,
    input  logic [CW-1:0]     i_count,
    input  logic [ID_W-1:0]   i_id,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_dl,
    input  logic [ID_W-1:0]   i_up_id,
    input  logic [TIME_W-1:0] i_up_dl,
    input  logic              i_up_live,
    input  t_scan             i_up_scan,
    input  logic [ID_W-1:0]   i_dn_id,
    input  logic [TIME_W-1:0] i_dn_dl,
    input  logic              i_dn_live,
    output logic [ID_W-1:0]   o_id,
    output logic [TIME_W-1:0] o_dl,
    output logic              o_live,
    output t_scan             o_scan
);

    localparam logic          PAR     = logic'(IDX % 2);
    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam bit            IS_HEAD = (IDX == 0);

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_dl;
    logic              r_live;
    t_scan             r_scan;

    logic lower, upper, in_use, live_now;

    always_comb begin
        lower    = (i_ctl.phase == PAR) && !LAST;
        upper    = (i_ctl.phase != PAR) && !IS_HEAD;
        in_use   = MY_IDX < i_count;
        live_now = in_use && (r_dl > i_now);
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            L_SORT: begin
                if (lower && !r_live && i_up_live) begin
                    r_id <= i_up_id;
                    r_dl <= i_up_dl;
                end else if (upper && !i_dn_live && r_live) begin
                    r_id <= i_dn_id;
                    r_dl <= i_dn_dl;
                end
            end
            L_REMOVE: begin
                if (!LAST && MY_IDX >= i_addr) begin
                    r_id <= i_up_id;
                    r_dl <= i_up_dl;
                end
            end
            L_SET_DL: begin
                if (MY_IDX == i_addr) r_dl <= i_dl;
            end
            L_APPEND: begin
                if (MY_IDX == i_addr) begin
                    r_id <= i_id;
                    r_dl <= i_dl;
                end
            end
            default: begin
            end
        endcase
    end

    // live flag and scan bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_scan <= '0;
        end else begin
            case (i_ctl.op)
                L_MARK: begin
                    r_live      <= live_now;
                    r_scan.live <= live_now;
                    r_scan.hit  <= live_now && (r_id == i_id);
                end
                L_SORT: begin
                    r_scan <= i_up_scan;
                    if (lower && !r_live && i_up_live) begin
                        r_live <= 1'b1;
                    end else if (upper && !i_dn_live && r_live) begin
                        r_live <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_id   = r_id;
    assign o_dl   = r_dl;
    assign o_live = r_live;
    assign o_scan = r_scan;

endmodule

// ===== hw/rtl/awq_list.sv =====
// one wait list: a chain of cells plus the head scanner and the fill count
// depends on awq_pkg and awq_cell
`timescale 1ns / 1ps
module awq_list import awq_pkg::*; #(
    parameter int LIST_DEPTH = P_LIST_DEPTH,
    parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_list_ctl         i_ctl,
    input  logic [CW-1:0]     i_addr,
    input  logic [ID_W-1:0]   i_id,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_dl,
    output logic [CW-1:0]     o_count,
    output logic              o_found,
    output logic [CW-1:0]     o_pos
);

    logic [ID_W-1:0]   c_id   [LIST_DEPTH];
    logic [TIME_W-1:0] c_dl   [LIST_DEPTH];
    logic              c_live [LIST_DEPTH];
    t_scan             c_scan [LIST_DEPTH];

    logic [CW-1:0] r_count, r_scan_cnt, r_pos;
    logic          r_found;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            localparam int UP = (g == LIST_DEPTH - 1) ? g : g + 1;
            localparam int DN = (g == 0) ? 0 : g - 1;
            awq_cell #(
                .CW   (CW),
                .IDX  (g),
                .LAST (g == LIST_DEPTH - 1)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (i_ctl),
                .i_addr    (i_addr),
                .i_count   (r_count),
                .i_id      (i_id),
                .i_now     (i_now),
                .i_dl      (i_dl),
                .i_up_id   (c_id[UP]),
                .i_up_dl   (c_dl[UP]),
                .i_up_live ((g == LIST_DEPTH - 1) ? 1'b0 : c_live[UP]),
                .i_up_scan ((g == LIST_DEPTH - 1) ? t_scan'('0) : c_scan[UP]),
                .i_dn_id   (c_id[DN]),
                .i_dn_dl   (c_dl[DN]),
                .i_dn_live ((g == 0) ? 1'b1 : c_live[DN]),
                .o_id      (c_id[g]),
                .o_dl      (c_dl[g]),
                .o_live    (c_live[g]),
                .o_scan    (c_scan[g])
            );
        end
    endgenerate

    // head scanner: counts survivors in order and finds the first hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_cnt <= '0;
            r_found    <= 1'b0;
            r_pos      <= '0;
        end else begin
            case (i_ctl.op)
                L_MARK: begin
                    r_scan_cnt <= '0;
                    r_found    <= 1'b0;
                end
                L_SORT: begin
                    if (c_scan[0].live) begin
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                        if (c_scan[0].hit && !r_found) begin
                            r_found <= 1'b1;
                            r_pos   <= r_scan_cnt;
                        end
                    end
                end
                L_COMMIT: r_count <= r_scan_cnt;
                L_REMOVE: r_count <= r_count - 1'b1;
                L_APPEND: r_count <= r_count + 1'b1;
                default: begin
                end
            endcase
        end
    end

    assign o_count = r_count;
    assign o_found = r_found;
    assign o_pos   = r_pos;

endmodule

// ===== hw/rtl/awq_checker.sv =====
// port-level checker for the admission wait queue, bound to the top level
// depends on two_class_admission_wait_queue_macros.svh and awq_pkg
`timescale 1ns / 1ps
`include "two_class_admission_wait_queue_macros.svh"
module awq_checker import awq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_always_admit,
    input logic              o_done,
    input logic [SLOT_W-1:0] o_slot,
    input logic              o_queue_full
);

    `AWQ_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result beat while busy")
    `AWQ_ASSERT_IMPL(a_full_beat, i_clk, i_rst_n, o_done && o_queue_full, o_slot != '0, "full flag with slot 0")
    `AWQ_ASSERT_NEXT(a_bypass, i_clk, i_rst_n, start && !busy && i_always_admit,
        o_done && o_slot == '0 && !o_queue_full, "bypass not answered with slot 0")
    `AWQ_ASSERT_NEXT(a_queue_busy, i_clk, i_rst_n, start && !busy && !i_always_admit,
        busy && !o_done, "queued request did not go busy")

endmodule

bind two_class_admission_wait_queue awq_checker u_awq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_always_admit (i_always_admit),
    .o_done         (o_done),
    .o_slot         (o_slot),
    .o_queue_full   (o_queue_full)
);

// ===== verif/two_class_admission_wait_queue_tb.sv =====
// testbench for the two-class admission wait queue: directed and random login traffic
// checked beat by beat against a behavioral queue model; depends on awq_pkg and the rtl
`timescale 1ns / 1ps
module two_class_admission_wait_queue_tb;
    import awq_pkg::*;

    localparam int DEPTH = P_LIST_DEPTH;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // list index in the model: priority first, then normal
    localparam int PRIO = 0;
    localparam int NORM = 1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              full;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ID_W-1:0]   i_client_id;
    logic              i_always_admit;
    logic              i_priority_class;
    logic [CAP_W-1:0]  i_admitted_now;
    logic [TIME_W-1:0] i_now_ms;
    logic              i_cfg_we;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              o_done;
    logic [SLOT_W-1:0] o_slot;
    logic              o_queue_full;

    two_class_admission_wait_queue u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_client_id      (i_client_id),
        .i_always_admit   (i_always_admit),
        .i_priority_class (i_priority_class),
        .i_admitted_now   (i_admitted_now),
        .i_now_ms         (i_now_ms),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_slot           (o_slot),
        .o_queue_full     (o_queue_full)
    );

    // model state: two ordered wait lists and the capacity register
    logic [ID_W-1:0]   q_ids [2][DEPTH];
    logic [TIME_W-1:0] q_dl  [2][DEPTH];
    int                q_cnt [2];
    logic [CAP_W-1:0]  capacity;

    t_answer answer_q[$];
    int      err_cnt;

    // traffic state
    logic [TIME_W-1:0] clock_ms;
    logic [ID_W-1:0]   id_pool [96];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    // wait time grows with the slot tier, saturating at the top of the time range
    function automatic logic [TIME_W-1:0] deadline_for(input logic [TIME_W-1:0] now,
                                                       input int slot);
        longint unsigned tier;
        longint unsigned sum;
        if (slot < 5) tier = 5;
        else if (slot < 10) tier = 10;
        else if (slot < 20) tier = 20;
        else if (slot < 50) tier = 60;
        else tier = 120;
        sum = longint'(now) + (tier + 15) * 1000;
        return (sum > longint'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // compute the answer for one accepted request and update the lists
    function automatic t_answer admission_predict(input logic [ID_W-1:0] id,
                                                  input logic bypass,
                                                  input logic prio,
                                                  input logic [CAP_W-1:0] online,
                                                  input logic [TIME_W-1:0] now);
        t_answer ans;
        int      w;
        int      pos;
        int      lst;
        int      slot;
        int      tgt;
        ans = '0;
        if (bypass) return ans;
        // drop expired entries, survivors packed in order
        for (int l = 0; l < 2; l++) begin
            w = 0;
            for (int r = 0; r < q_cnt[l]; r++) begin
                if (q_dl[l][r] > now) begin
                    q_ids[l][w] = q_ids[l][r];
                    q_dl[l][w]  = q_dl[l][r];
                    w++;
                end
            end
            q_cnt[l] = w;
        end
        if (capacity == 0 || (q_cnt[PRIO] == 0 && q_cnt[NORM] == 0 && online < capacity))
            return ans;
        // first match wins, priority list searched first
        pos = -1;
        lst = PRIO;
        for (int l = 0; l < 2 && pos < 0; l++) begin
            for (int i = 0; i < q_cnt[l] && pos < 0; i++) begin
                if (q_ids[l][i] == id) begin
                    pos = i;
                    lst = l;
                end
            end
        end
        if (pos >= 0) begin
            slot = pos + 1 + ((lst == NORM) ? q_cnt[PRIO] : 0);
            if (int'(online) + slot <= int'(capacity)) begin
                for (int i = pos; i + 1 < q_cnt[lst]; i++) begin
                    q_ids[lst][i] = q_ids[lst][i+1];
                    q_dl[lst][i]  = q_dl[lst][i+1];
                end
                q_cnt[lst]--;
                slot = 0;
            end else begin
                q_dl[lst][pos] = deadline_for(now, slot);
            end
        end else begin
            tgt  = prio ? PRIO : NORM;
            slot = q_cnt[PRIO] + 1 + (prio ? 0 : q_cnt[NORM]);
            if (q_cnt[tgt] >= DEPTH) begin
                ans.full = 1'b1;
            end else begin
                q_ids[tgt][q_cnt[tgt]] = id;
                q_dl[tgt][q_cnt[tgt]]  = deadline_for(now, slot);
                q_cnt[tgt]++;
            end
        end
        ans.slot = slot[SLOT_W-1:0];
        return ans;
    endfunction

    // one request beat; start is left high so back-to-back beats need no toggle
    task automatic send_request(input logic [ID_W-1:0] id, input logic bypass,
                                input logic prio, input logic [CAP_W-1:0] online,
                                input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        start            <= 1'b1;
        i_client_id      <= id;
        i_always_admit   <= bypass;
        i_priority_class <= prio;
        i_admitted_now   <= online;
        i_now_ms         <= now;
        do @(posedge i_clk); while (busy);
        answer_q.push_back(admission_predict(id, bypass, prio, online, now));
    endtask

    // sender gap: mostly none or short, now and then long
    task automatic sender_gap();
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: n = 0;
            19:                     n = $urandom_range(40, 300);
            default:                n = $urandom_range(1, 6);
        endcase
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // stop sending until every answer has come back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // capacity write, only with the block idle
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        capacity     = value;
    endtask

    // answer checker: the receiver cannot stall, every done beat is taken
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_done) begin
            if (answer_q.size() == 0) begin
                note_mismatch("answer beat with nothing expected");
            end else begin
                exp_ans = answer_q.pop_front();
                if (o_slot !== exp_ans.slot)
                    note_mismatch($sformatf("slot got %0d exp %0d", o_slot, exp_ans.slot));
                if (o_queue_full !== exp_ans.full)
                    note_mismatch($sformatf("queue_full got %b exp %b",
                                            o_queue_full, exp_ans.full));
            end
        end
    end

    // hand-picked cases: extremes, bypass, rejoin, expiry, saturation
    task automatic test_directed();
        set_capacity(16'd0);
        send_request(32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF, TIME_MAX); // queueing disabled
        set_capacity(16'd10);
        send_request(32'd1, 1'b0, 1'b0, 16'd3, 40'd1000);         // empty with room
        send_request(32'd1, 1'b0, 1'b0, 16'd10, 40'd1000);        // new normal, slot 1
        send_request(32'd2, 1'b0, 1'b1, 16'd10, 40'd1100);        // new priority ahead
        send_request(32'd0, 1'b0, 1'b0, 16'd10, 40'd1200);        // id zero, slot 3
        send_request(32'd7, 1'b1, 1'b0, 16'hFFFF, 40'd1300);      // bypass, no change
        send_request(32'd1, 1'b0, 1'b0, 16'd10, 40'd1400);        // rejoin, refresh
        send_request(32'd1, 1'b0, 1'b1, 16'd8, 40'd1500);         // rejoin, admitted
        send_request(32'd0, 1'b0, 1'b0, 16'd9, 40'd1600);         // slot 2 doesn't fit
        send_request(32'd2, 1'b0, 1'b0, 16'd0, 40'd500);          // time goes back
        send_request(32'd0, 1'b0, 1'b0, 16'd10, 40'd21600);       // exactly at deadline
        send_request(32'd9, 1'b0, 1'b1, 16'd10, TIME_MAX - 40'd5); // deadline saturates
        send_request(32'd9, 1'b0, 1'b1, 16'd10, TIME_MAX);        // purged at max time
        send_request(32'hFFFF_FFFF, 1'b0, 1'b0, 16'hFFFF, 40'd0);
        send_request(32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 40'd10);
        set_capacity(16'hFFFF);
        send_request(32'h8000_0001, 1'b0, 1'b0, 16'hFFFF, 40'h55_5555_5555);
        send_request(32'h8000_0001, 1'b0, 1'b0, 16'hFFFE, 40'hAA_AAAA_AAAA);
    endtask

    // random traffic; flood keeps clients queued so lists fill and overflow
    task automatic test_random(input int n_items, input bit flood);
        logic [ID_W-1:0]  id;
        logic [CAP_W-1:0] online;
        int               pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 199);
            if (pick == 0) clock_ms = TIME_W'({$urandom, $urandom});
            else if (pick < 5) clock_ms += $urandom_range(10_000, 200_000);
            else clock_ms += flood ? $urandom_range(0, 150) : $urandom_range(0, 600);
            if (clock_ms > TIME_MAX - 40'd300_000 && pick > 1) clock_ms = TIME_W'($urandom);
            id = (flood || $urandom_range(0, 4) == 0) ? $urandom
                                                       : id_pool[$urandom_range(0, 95)];
            if (flood && $urandom_range(0, 5) == 0) online = 16'hFFFF;
            else if ($urandom_range(0, 9) == 0) online = CAP_W'($urandom);
            else if (flood) online = capacity;
            else if (capacity > 16'hFFF0)
                online = capacity - CAP_W'($urandom_range(0, 12));
            else online = CAP_W'($urandom_range(0, int'(capacity) + 3));
            send_request(id, $urandom_range(0, 15) == 0, $urandom_range(0, 2) == 0,
                         online, clock_ms);
            sender_gap();
        end
    endtask

    initial begin
        err_cnt          = 0;
        capacity         = '0;
        clock_ms         = 40'd50_000;
        start            = 1'b0;
        i_client_id      = '0;
        i_always_admit   = 1'b0;
        i_priority_class = 1'b0;
        i_admitted_now   = '0;
        i_now_ms         = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        q_cnt[PRIO]      = 0;
        q_cnt[NORM]      = 0;
        foreach (id_pool[i]) id_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_capacity(16'd0);
        test_random(150, 1'b0);
        set_capacity(16'd40);
        test_random(320, 1'b1);
        test_random(200, 1'b0);
        set_capacity(16'd1);
        test_random(200, 1'b0);
        set_capacity(CAP_W'($urandom));
        test_random(150, 1'b0);
        set_capacity(16'hFFFF);
        test_random(200, 1'b0);
        set_capacity(16'd20);
        test_random(180, 1'b1);
        test_random(180, 1'b0);

        // finish: everything answered, then a latency's worth of quiet
        drain();
        repeat (DEPTH + 20) @(negedge i_clk);
        if (answer_q.size() != 0)
            note_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== two_class_admission_wait_queue.f =====
+incdir+hw/rtl
hw/rtl/awq_pkg.sv
hw/rtl/awq_cell.sv
hw/rtl/awq_list.sv
hw/rtl/two_class_admission_wait_queue.sv
hw/rtl/awq_checker.sv
verif/two_class_admission_wait_queue_tb.sv
